// File: hdl/beg_pkg.sv
// brightness envelope generator: shared types, codes and constants
// no dependencies
package beg_pkg;

	localparam int FRAME_BITS_DEF      = 16;
	localparam int LEVEL_FRAC_BITS_DEF = 16;
	localparam int LVL_W               = 32;
	localparam int NUM_W               = 34;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_RAMPN = 3'd1,
		OP_RAMPS = 3'd2,
		OP_ACCEL = 3'd3,
		OP_LOOP  = 3'd4,
		OP_BEAT  = 3'd5,
		OP_STOP  = 3'd6,
		OP_NONE  = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_LIN  = 3'd1,
		MODE_ACC  = 3'd2,
		MODE_LOOP = 3'd3,
		MODE_BEAT = 3'd4
	} mode_t;

	localparam logic CFG_TOP    = 1'b0;
	localparam logic CFG_BOTTOM = 1'b1;

	// saturate a 34 bit signed value to 32 bits
	function automatic logic [LVL_W-1:0] sat32(input logic signed [NUM_W-1:0] v);
		logic signed [NUM_W-1:0] hi;
		logic signed [NUM_W-1:0] lo;
		hi = NUM_W'(signed'(33'sh0_7FFF_FFFF));
		lo = -NUM_W'(signed'(33'sh0_8000_0000));
		if (v > hi)      sat32 = 32'h7FFF_FFFF;
		else if (v < lo) sat32 = 32'h8000_0000;
		else             sat32 = v[LVL_W-1:0];
	endfunction

endpackage

// File: hdl/brightness_envelope_generator.sv
// brightness envelope generator top level: sequencer, state and shared divider
// depends on beg_pkg and beg_div
//
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid/tready    | command or tick item
//  m_axis  | out | tvalid/tready    | level, mode, tick count
//  cfg     | in  | cfg_we           | top_level (0), bottom_level (1)
//
// an item passes from accept through exec, through the divider state when it
// needs a division, and waits in output until its result is taken; the divider
// resolves one quotient bit per cycle over a 33 bit magnitude
// asynchronous reset restores level 1.0, idle mode and the default bounds
// input ready drops while an item is in work or its result is not yet taken
module brightness_envelope_generator import beg_pkg::*; #(
	parameter int FRAME_BITS      = FRAME_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// op[2:0], target_level[34:3], step_size[66:35], accel[98:67],
	// total_frames[114:99], attack_frames[130:115], rest_frames[146:131],
	// half_cycles[162:147], zero fill to 168
	input  logic [167:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// level[31:0], mode[34:32], tick_count[66:35], zero fill to 72
	output logic [71:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int FB = FRAME_BITS;
	localparam logic [LVL_W-1:0] LVL_ONE   = LVL_W'(64'(1) << LEVEL_FRAC_BITS);
	localparam logic [LVL_W-1:0] LVL_TENTH = LVL_W'(((64'(1) << LEVEL_FRAC_BITS) + 5) / 10);
	// default top bound of 1000.0, clipped to the largest level
	localparam longint TOP_FULL = 1000 * (longint'(1) << LEVEL_FRAC_BITS);
	localparam logic [LVL_W-1:0] TOP_RST = (TOP_FULL > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF
		: LVL_W'(TOP_FULL);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	// what to do with the quotient once the divider finishes
	typedef enum logic [1:0] {
		DV_VEL   = 2'd0,  // plain velocity
		DV_RAMPN = 2'd1,  // zero velocity sends to idle
		DV_LOOP  = 2'd2   // zero velocity becomes a tenth
	} dv_t;

	state_t state_q;
	dv_t    dv_q;

	// decoded input
	logic [2:0]            in_op;
	logic signed [31:0]    in_tgt, in_step, in_acc;
	logic [15:0]           in_total, in_att, in_rest, in_halves;

	logic [2:0]            op_q;
	logic signed [31:0]    tgt_in_q, step_in_q, acc_in_q;
	logic [FB-1:0]         total_q, att_q, rest_q;
	logic [15:0]           halves_q;

	// envelope state
	logic signed [31:0] top_q, bot_q;
	logic signed [31:0] lvl_q, vel_q, accr_q, tgt_q;
	logic [2:0]         mode_q;
	logic [15:0]        hcnt_q, hlim_q;
	logic [FB-1:0]      period_q, attl_q, fib_q;
	logic [FB:0]        down_q;
	logic [1:0]         phase_q;
	logic [31:0]        ticks_q;

	// shared divider
	logic                    div_start, div_done;
	logic signed [NUM_W-1:0] div_num;
	logic [FB:0]             div_den;
	logic [LVL_W-1:0]        div_quo;

	beg_div #(.FRAME_BITS(FRAME_BITS)) u_div (
		.clk, .arst_n,
		.start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	assign in_op     = s_axis_tdata[2:0];
	assign in_tgt    = s_axis_tdata[34:3];
	assign in_step   = s_axis_tdata[66:35];
	assign in_acc    = s_axis_tdata[98:67];
	assign in_total  = s_axis_tdata[114:99];
	assign in_att    = s_axis_tdata[130:115];
	assign in_rest   = s_axis_tdata[146:131];
	assign in_halves = s_axis_tdata[162:147];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {5'd0, ticks_q, mode_q, lvl_q};

	// combinational step: the saturating adds of level and velocity and the compares of one item
	logic signed [31:0] sum_lvl;
	logic signed [31:0] sum_vel;
	logic [FB-1:0]      fib_nx;
	logic [FB+1:0]      att_rest;

	assign sum_lvl  = sat32(NUM_W'(lvl_q) + NUM_W'(vel_q));
	assign sum_vel  = sat32(NUM_W'(vel_q) + NUM_W'(accr_q));
	assign fib_nx   = fib_q + 1'b1;
	assign att_rest = (FB+2)'(att_q) + (FB+2)'(rest_q);

	function automatic logic [15:0] half_inc(input logic [15:0] c);
		half_inc = c + 16'd1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dv_q    <= DV_VEL;
			top_q   <= TOP_RST;
			bot_q   <= '0;
			lvl_q   <= LVL_ONE;
			vel_q   <= '0;
			accr_q  <= '0;
			tgt_q   <= LVL_ONE;
			mode_q  <= MODE_IDLE;
			hcnt_q  <= '0;
			hlim_q  <= '0;
			period_q <= '0;
			attl_q  <= '0;
			down_q  <= '0;
			fib_q   <= '0;
			phase_q <= '0;
			ticks_q <= '0;
			div_start <= 1'b0;
			div_num <= '0;
			div_den <= '0;
			op_q <= '0;
			tgt_in_q <= '0; step_in_q <= '0; acc_in_q <= '0;
			total_q <= '0; att_q <= '0; rest_q <= '0; halves_q <= '0;
		end else begin
			div_start <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_TOP) top_q <= cfg_data;
				else                      bot_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q      <= in_op;
						tgt_in_q  <= in_tgt;
						step_in_q <= in_step;
						acc_in_q  <= in_acc;
						total_q   <= FB'(in_total);
						att_q     <= FB'(in_att);
						rest_q    <= FB'(in_rest);
						halves_q  <= in_halves;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_OUT;
					dv_q    <= DV_VEL;
					case (op_q)
						OP_TICK: begin
							if (mode_q != MODE_IDLE) begin
								ticks_q <= ticks_q + 1'b1;
								case (mode_q)
									MODE_LIN, MODE_ACC: begin
										if (mode_q == MODE_ACC) vel_q <= sum_vel;
										if ((vel_q > 0 && tgt_q <= sum_lvl) ||
										    (vel_q < 0 && tgt_q >= sum_lvl)) begin
											lvl_q  <= tgt_q;
											mode_q <= MODE_IDLE;
										end else begin
											lvl_q <= sum_lvl;
										end
									end
									MODE_LOOP: begin
										if (top_q <= sum_lvl || bot_q >= sum_lvl) begin
											lvl_q <= (top_q <= sum_lvl) ? top_q : bot_q;
											div_num <= (top_q <= sum_lvl)
												? -((NUM_W'(top_q) - NUM_W'(bot_q)) <<< 1)
												: ((NUM_W'(top_q) - NUM_W'(bot_q)) <<< 1);
											div_den <= {1'b0, period_q};
											div_start <= 1'b1;
											state_q <= ST_DIV;
											hcnt_q <= half_inc(hcnt_q);
											if (hlim_q != 0 && half_inc(hcnt_q) == hlim_q)
												mode_q <= MODE_IDLE;
										end else begin
											lvl_q <= sum_lvl;
										end
									end
									default: begin
										fib_q <= fib_nx;
										case (phase_q)
											2'd0: begin
												if (fib_nx >= attl_q) begin
													lvl_q <= top_q;
													div_num <= NUM_W'(bot_q) - NUM_W'(top_q);
													div_den <= down_q;
													div_start <= 1'b1;
													state_q <= ST_DIV;
													phase_q <= 2'd1;
													hcnt_q <= half_inc(hcnt_q);
													if (hlim_q != 0 && half_inc(hcnt_q) == hlim_q)
														mode_q <= MODE_IDLE;
												end else begin
													lvl_q <= sum_lvl;
												end
											end
											2'd1: begin
												if ((FB+1)'(fib_nx) >= (FB+1)'(attl_q) + down_q) begin
													lvl_q   <= bot_q;
													vel_q   <= '0;
													phase_q <= 2'd2;
												end else begin
													lvl_q <= sum_lvl;
												end
											end
											2'd2: begin
												if (fib_nx >= period_q) begin
													div_num <= NUM_W'(top_q) - NUM_W'(lvl_q);
													div_den <= {1'b0, attl_q};
													div_start <= 1'b1;
													state_q <= ST_DIV;
													fib_q <= '0;
													phase_q <= 2'd0;
													hcnt_q <= half_inc(hcnt_q);
													if (hlim_q != 0 && half_inc(hcnt_q) == hlim_q)
														mode_q <= MODE_IDLE;
												end
											end
											default: ;
										endcase
									end
								endcase
							end
						end
						OP_RAMPN: begin
							mode_q  <= MODE_LIN;
							tgt_q   <= tgt_in_q;
							div_num <= NUM_W'(tgt_in_q) - NUM_W'(lvl_q);
							div_den <= {1'b0, total_q};
							div_start <= 1'b1;
							dv_q    <= DV_RAMPN;
							state_q <= ST_DIV;
						end
						OP_RAMPS: begin
							mode_q <= MODE_LIN;
							tgt_q  <= tgt_in_q;
							if (tgt_in_q > lvl_q)      vel_q <= step_in_q;
							else if (tgt_in_q < lvl_q) vel_q <= sat32(-NUM_W'(step_in_q));
							else                       vel_q <= '0;
						end
						OP_ACCEL: begin
							mode_q <= MODE_ACC;
							tgt_q  <= tgt_in_q;
							vel_q  <= step_in_q;
							accr_q <= acc_in_q;
						end
						OP_LOOP: begin
							mode_q   <= MODE_LOOP;
							hcnt_q   <= '0;
							hlim_q   <= halves_q;
							period_q <= total_q;
							div_num  <= NUM_W'(top_q) - NUM_W'(lvl_q);
							div_den  <= {2'b0, total_q[FB-1:1]};
							div_start <= 1'b1;
							dv_q     <= DV_LOOP;
							state_q  <= ST_DIV;
						end
						OP_BEAT: begin
							mode_q   <= MODE_BEAT;
							hcnt_q   <= '0;
							hlim_q   <= halves_q;
							attl_q   <= att_q;
							period_q <= total_q;
							fib_q    <= '0;
							down_q   <= (att_rest > (FB+2)'(total_q)) ? '0
								: (FB+1)'((FB+2)'(total_q) - att_rest);
							div_start <= 1'b1;
							state_q  <= ST_DIV;
							if (att_q != '0) begin
								div_num <= NUM_W'(top_q) - NUM_W'(lvl_q);
								div_den <= {1'b0, att_q};
								phase_q <= 2'd0;
							end else begin
								lvl_q   <= top_q;
								div_num <= NUM_W'(bot_q) - NUM_W'(top_q);
								div_den <= (att_rest > (FB+2)'(total_q)) ? '0
									: (FB+1)'((FB+2)'(total_q) - att_rest);
								hcnt_q  <= 16'd1;
								phase_q <= 2'd1;
							end
						end
						OP_STOP: mode_q <= MODE_IDLE;
						default: ;
					endcase
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
						vel_q   <= div_quo;
						if (div_quo == '0) begin
							if (dv_q == DV_RAMPN) mode_q <= MODE_IDLE;
							if (dv_q == DV_LOOP)  vel_q  <= LVL_TENTH;
						end
					end
				end
				ST_OUT: begin
					if (m_axis_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no new item is taken while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
	// a result appears only after an accepted item
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_EXEC || $past(state_q) == ST_DIV)
		else $error("result without item");
	// ticks count only on tick items
	a_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) != ST_EXEC |-> $stable(ticks_q)) else $error("stray tick count");
endmodule

// File: hdl/beg_div.sv
// brightness envelope generator: iterative signed divider, one quotient bit a cycle
// truncates toward zero, zero divisor acts as one, result saturated to 32 bits
// depends on beg_pkg
module beg_div import beg_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [FRAME_BITS:0]     den,
	output logic                    done,
	output logic [LVL_W-1:0]        quo
);
	localparam int MAG_W = NUM_W - 1;
	localparam int CW    = $clog2(MAG_W + 1);

	logic [MAG_W-1:0]     rem_q;
	logic [MAG_W-1:0]     q_q;
	logic [FRAME_BITS:0]  den_q;
	logic                 neg_q;
	logic                 busy_q;
	logic [CW-1:0]        cnt_q;
	logic [FRAME_BITS+1:0] part;
	logic [FRAME_BITS+1:0] trial;
	logic                 fit;
	logic signed [NUM_W-1:0] sq;

	// partial remainder is always below the divisor, so it fits den width
	assign part  = {rem_q[FRAME_BITS:0], q_q[MAG_W-1]};
	assign trial = part - {1'b0, den_q};
	assign fit   = !trial[FRAME_BITS+1];
	assign sq    = neg_q ? -signed'({1'b0, q_q}) : signed'({1'b0, q_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			q_q   <= num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
			rem_q <= '0;
			den_q <= (den == '0) ? (FRAME_BITS+1)'(1) : den;
		end else if (busy_q) begin
			rem_q <= MAG_W'(fit ? trial[FRAME_BITS:0] : part[FRAME_BITS:0]);
			q_q   <= {q_q[MAG_W-2:0], fit};
		end
	end

	assign quo = sat32(sq);
endmodule
